@@ rtl/core/pcs_pkg.sv @@
// Package: shared constants for the property chain store.
package pcs_pkg;
  localparam int POOL_DEPTH_DEF = 1024;
  localparam int CAP_W          = 11;
  localparam int OP_W           = 3;
  localparam int WORD_W         = 32;
  localparam int STATUS_W       = 2;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_UNLINK  = 3'd1;
  localparam logic [OP_W-1:0] OP_SETVAL  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOUSE = 2'd2;
endpackage

@@ rtl/core/pcs_if.sv @@
// Interfaces: request and result channels of the property chain store.
interface pcs_req_if #(parameter int LW = 11, parameter int IW = 10);
  logic          valid;
  logic          ready;
  logic [2:0]    opcode;
  logic [LW-1:0] chain_head_in;
  logic [IW-1:0] record_index;
  logic [31:0]   prop_key;
  logic [31:0]   prop_type;
  logic [31:0]   prop_value;
  modport source (output valid, opcode, chain_head_in, record_index, prop_key, prop_type,
                  prop_value, input ready);
  modport sink (input valid, opcode, chain_head_in, record_index, prop_key, prop_type,
                prop_value, output ready);
endinterface

interface pcs_rsp_if #(parameter int LW = 11);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [LW-1:0] new_index;
  logic [LW-1:0] chain_head_out;
  logic [31:0]   read_key;
  logic [31:0]   read_type;
  logic [31:0]   read_value;
  logic [LW-1:0] read_next;
  logic          read_in_use;
  modport source (output valid, status, new_index, chain_head_out, read_key, read_type,
                  read_value, read_next, read_in_use, input ready);
  modport sink (input valid, status, new_index, chain_head_out, read_key, read_type,
                read_value, read_next, read_in_use, output ready);
endinterface

@@ rtl/core/pcs_front.sv @@
// Front end: request capture into a short queue.
module pcs_front import pcs_pkg::*; #(
  parameter int LW = 11,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  pcs_req_if.sink       in_req,
  output logic          q_valid,
  input  logic          q_pop,
  output logic [OP_W-1:0] q_op,
  output logic [LW-1:0] q_head,
  output logic [IW-1:0] q_idx,
  output logic [WORD_W-1:0] q_key,
  output logic [WORD_W-1:0] q_type,
  output logic [WORD_W-1:0] q_val
);
  localparam int QW = OP_W + LW + IW + 3*WORD_W;
  logic [QW-1:0] q_mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push;

  assign in_req.ready = (cnt_r != 2'd2);
  assign push = in_req.valid && in_req.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign {q_op, q_head, q_idx, q_key, q_type, q_val} = q_mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= {in_req.opcode, in_req.chain_head_in, in_req.record_index,
                        in_req.prop_key, in_req.prop_type, in_req.prop_value};
    end
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif
endmodule

@@ rtl/core/pcs_back.sv @@
// Back end: record memories, free stack and operation sequencer.
module pcs_back import pcs_pkg::*; #(
  parameter int DEPTH = POOL_DEPTH_DEF,
  parameter int LW = 11,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic          q_valid,
  output logic          q_pop,
  input  logic [OP_W-1:0] q_op,
  input  logic [LW-1:0] q_head,
  input  logic [IW-1:0] q_idx,
  input  logic [WORD_W-1:0] q_key,
  input  logic [WORD_W-1:0] q_type,
  input  logic [WORD_W-1:0] q_val,
  pcs_rsp_if.source     out_rsp
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (LW > CAP_W) ? LW : CAP_W;
  localparam logic [LW-1:0] NONE = LW'(DEPTH);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EXE  = 4'd3;
  localparam logic [3:0] S_UL1  = 4'd4;
  localparam logic [3:0] S_UL2  = 4'd5;
  localparam logic [3:0] S_RLR  = 4'd6;
  localparam logic [3:0] S_RLW  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_FPOP = 4'd9;

  logic [3*WORD_W-1:0] words_mem [DEPTH];
  logic [LW-1:0]       prev_mem  [DEPTH];
  logic [LW-1:0]       next_mem  [DEPTH];
  logic                used_mem  [DEPTH];
  logic [AW-1:0]       fstk_mem  [DEPTH];

  logic [3:0] st_r;
  logic [AW-1:0] clr_r;
  logic [CAP_W-1:0] cap_r;
  logic [LW-1:0] fcnt_r, bump_r;
  logic [OP_W-1:0] op_r;
  logic [LW-1:0] head_r, cur_r, id_r;
  logic [AW-1:0] idx_r;
  logic [WORD_W-1:0] key_r, typ_r, val_r;
  // registered read data
  logic [3*WORD_W-1:0] w_rd_r;
  logic [LW-1:0] p_rd_r, n_rd_r, un_p_r, un_n_r;
  logic u_idx_r, u_head_r;
  logic [AW-1:0] f_rd_r;
  // read addresses
  logic [AW-1:0] ra_idx, ra_head;

  logic ovld_r;
  logic [1:0] o_st_r;
  logic [LW-1:0] o_ni_r, o_ho_r, o_rn_r;
  logic [WORD_W-1:0] o_k_r, o_t_r, o_v_r;
  logic o_ru_r;

  logic head_none, head_ok, idx_live, cur_live;
  logic [LW-1:0] cap_eff;

  assign head_none = (head_r == NONE);
  assign head_ok   = head_none || (head_r < NONE && u_head_r);
  assign idx_live  = u_idx_r;
  assign cap_eff   = (CW'(cap_r) > CW'(DEPTH)) ? NONE : LW'(cap_r);
  assign cur_live  = (cur_r < NONE) && u_head_r;
  assign ra_idx    = q_idx[AW-1:0];
  assign ra_head   = q_head[AW-1:0];

  assign q_pop = (st_r == S_IDLE) && q_valid && !ovld_r;

  assign out_rsp.valid = ovld_r;
  assign out_rsp.status = o_st_r;
  assign out_rsp.new_index = o_ni_r;
  assign out_rsp.chain_head_out = o_ho_r;
  assign out_rsp.read_key = o_k_r;
  assign out_rsp.read_type = o_t_r;
  assign out_rsp.read_value = o_v_r;
  assign out_rsp.read_next = o_rn_r;
  assign out_rsp.read_in_use = o_ru_r;

  function automatic logic in_rng(input logic [LW-1:0] v);
    return v < NONE;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      cap_r  <= CAP_W'(1024);
      fcnt_r <= '0;
      bump_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (ovld_r && out_rsp.ready) ovld_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          used_mem[clr_r] <= 1'b0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH-1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            op_r <= q_op; head_r <= q_head; cur_r <= q_head;
            idx_r <= q_idx[AW-1:0]; key_r <= q_key; typ_r <= q_type; val_r <= q_val;
            w_rd_r <= words_mem[ra_idx];
            p_rd_r <= prev_mem[ra_idx];
            n_rd_r <= next_mem[ra_idx];
            u_idx_r <= (LW'(q_idx) < NONE) && used_mem[ra_idx];
            u_head_r <= used_mem[ra_head];
            f_rd_r <= fstk_mem[AW'(fcnt_r - 1'b1)];
            o_st_r <= ST_OK; o_ni_r <= NONE; o_ho_r <= q_head;
            o_k_r <= '0; o_t_r <= '0; o_v_r <= '0; o_rn_r <= NONE; o_ru_r <= 1'b0;
            st_r <= S_EXE;
          end
        end
        S_EXE: begin
          st_r <= S_OUT;
          case (op_r)
            OP_ADD: begin
              if (!head_ok) o_st_r <= ST_NOUSE;
              else if (fcnt_r == '0 && bump_r >= cap_eff) o_st_r <= ST_FULL;
              else begin
                if (fcnt_r != '0) begin
                  fcnt_r <= fcnt_r - 1'b1; id_r <= LW'(f_rd_r);
                  st_r <= S_FPOP;
                end else begin
                  bump_r <= bump_r + 1'b1; id_r <= bump_r;
                  st_r <= S_FPOP;
                end
              end
            end
            OP_UNLINK: begin
              if (!idx_live) o_st_r <= ST_NOUSE;
              else begin
                un_p_r <= p_rd_r; un_n_r <= n_rd_r;
                used_mem[idx_r] <= 1'b0;
                if (fcnt_r < NONE) begin
                  fstk_mem[fcnt_r[AW-1:0]] <= idx_r;
                  fcnt_r <= fcnt_r + 1'b1;
                end
                if (!in_rng(p_rd_r)) o_ho_r <= n_rd_r;
                st_r <= S_UL1;
              end
            end
            OP_SETVAL: begin
              if (!idx_live) o_st_r <= ST_NOUSE;
              else words_mem[idx_r][WORD_W-1:0] <= val_r;
            end
            OP_READ: begin
              if (!idx_live) o_st_r <= ST_NOUSE;
              else begin
                {o_k_r, o_t_r, o_v_r} <= w_rd_r;
                o_rn_r <= n_rd_r; o_ru_r <= 1'b1;
              end
            end
            OP_RELEASE: begin
              if (!head_ok) o_st_r <= ST_NOUSE;
              else begin
                o_ho_r <= NONE;
                st_r <= S_RLW;
              end
            end
            default: ;
          endcase
        end
        S_FPOP: begin
          if (id_r < NONE) begin
            used_mem[id_r[AW-1:0]] <= 1'b1;
            words_mem[id_r[AW-1:0]] <= {key_r, typ_r, val_r};
            prev_mem[id_r[AW-1:0]] <= NONE;
            next_mem[id_r[AW-1:0]] <= head_r;
            if (!head_none) prev_mem[head_r[AW-1:0]] <= id_r;
            o_ni_r <= id_r; o_ho_r <= id_r;
          end
          st_r <= S_OUT;
        end
        S_UL1: begin
          if (in_rng(un_p_r)) next_mem[un_p_r[AW-1:0]] <= un_n_r;
          st_r <= S_UL2;
        end
        S_UL2: begin
          if (in_rng(un_n_r)) prev_mem[un_n_r[AW-1:0]] <= un_p_r;
          st_r <= S_OUT;
        end
        S_RLW: begin
          if (cur_live) begin
            used_mem[cur_r[AW-1:0]] <= 1'b0;
            if (fcnt_r < NONE) begin
              fstk_mem[fcnt_r[AW-1:0]] <= cur_r[AW-1:0];
              fcnt_r <= fcnt_r + 1'b1;
            end
            cur_r <= next_mem[cur_r[AW-1:0]];
            st_r <= S_RLR;
          end else st_r <= S_OUT;
        end
        S_RLR: begin
          u_head_r <= used_mem[cur_r[AW-1:0]];
          st_r <= S_RLW;
        end
        S_OUT: begin
          if (!ovld_r) begin
            ovld_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == S_EXE) else $error("pop outside idle");
  a_fcnt: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= NONE) else $error("free count overflow");
  a_bump: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= NONE) else $error("bump mark overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_rsp.ready |=> ovld_r && $stable(o_ho_r)) else $error("result lost");
`endif
endmodule

@@ rtl/core/property_chain_store.sv @@
// Top level: property chain store, front queue plus back-end sequencer.
// Usage:
//   in_*  : request channel (valid/ready), one operation per request.
//   out_* : result channel (valid/ready), exactly one result per request.
//   cfg_* : cfg_we/cfg_wdata write the capacity register; write only when idle.
// Sequencing: each request is executed, then its result is registered; an add
//   also writes the new record, an unlink patches the previous and then the
//   next link, and a release frees the linked records one at a time. The back
//   end takes the next request only after the result has been accepted.
// The two-entry front queue keeps accepting requests while the back end works.
// Reset: a clearing pass marks every record unused, one entry per cycle;
//   no request leaves the queue until it ends.
// Receiver stall: the result register holds; the back end waits, the queue
//   fills, then in_ready drops.
module property_chain_store import pcs_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  pcs_req_if.sink   in_req,
  pcs_rsp_if.source out_rsp
);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int IW = $clog2(POOL_DEPTH);

  logic q_valid, q_pop;
  logic [OP_W-1:0] q_op;
  logic [LW-1:0] q_head;
  logic [IW-1:0] q_idx;
  logic [WORD_W-1:0] q_key, q_type, q_val;

  pcs_front #(.LW(LW), .IW(IW)) u_front (
    .clk, .rst_n, .in_req, .q_valid, .q_pop, .q_op, .q_head, .q_idx,
    .q_key, .q_type, .q_val
  );

  pcs_back #(.DEPTH(POOL_DEPTH), .LW(LW), .IW(IW)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_pop, .q_op, .q_head, .q_idx,
    .q_key, .q_type, .q_val, .out_rsp
  );
endmodule

@@ sim/tb_property_chain_store.sv @@
// Testbench for property_chain_store: directed and random requests, checked in order.
module tb_property_chain_store import pcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = POOL_DEPTH_DEF;
  localparam logic [10:0] LINK_NONE = 11'd1024;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int NCHAIN = 4;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [10:0] head;
    logic [9:0] idx;
    logic [31:0] key;
    logic [31:0] ptype;
    logic [31:0] value;
  } op_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [10:0] new_index;
    logic [10:0] head_out;
    logic [31:0] rkey;
    logic [31:0] rtype;
    logic [31:0] rvalue;
    logic [10:0] rnext;
    logic rused;
  } op_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  pcs_req_if #(.LW(11), .IW(10)) req ();
  pcs_rsp_if #(.LW(11)) rsp ();

  property_chain_store dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_req(req), .out_rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // store image
  logic [31:0] rec_key [DEPTH];
  logic [31:0] rec_type [DEPTH];
  logic [31:0] rec_value [DEPTH];
  logic [10:0] rec_prev [DEPTH];
  logic [10:0] rec_next [DEPTH];
  logic rec_used [DEPTH];
  logic [9:0] free_lifo [DEPTH];
  int unsigned free_cnt;
  int unsigned bump;
  logic [CAP_W-1:0] capacity;

  op_rsp_t pending_results[$];
  logic [10:0] chain_heads [NCHAIN];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  function automatic bit is_live(logic [10:0] i);
    return i < DEPTH && rec_used[i[9:0]];
  endfunction

  function automatic void free_push(logic [10:0] i);
    if (free_cnt < DEPTH) begin
      free_lifo[free_cnt] = i[9:0];
      free_cnt++;
    end
  endfunction

  function automatic op_rsp_t predict_store_op(op_req_t r);
    op_rsp_t o;
    bit head_ok;
    int unsigned cap;
    logic [10:0] id;
    logic [10:0] cur;
    logic [10:0] nxt;
    logic [10:0] p;
    logic [10:0] n;
    o = '0;
    o.status = ST_OK;
    o.new_index = LINK_NONE;
    o.head_out = r.head;
    o.rnext = LINK_NONE;
    head_ok = (r.head == LINK_NONE) || is_live(r.head);
    case (r.opcode)
      OP_ADD: begin
        cap = (capacity > DEPTH) ? DEPTH : capacity;
        if (!head_ok) begin
          o.status = ST_NOUSE;
        end else if (free_cnt == 0 && bump >= cap) begin
          o.status = ST_FULL;
        end else begin
          if (free_cnt > 0) begin
            free_cnt--;
            id = {1'b0, free_lifo[free_cnt]};
          end else begin
            id = bump[10:0];
            bump++;
          end
          rec_used[id[9:0]] = 1'b1;
          rec_key[id[9:0]] = r.key;
          rec_type[id[9:0]] = r.ptype;
          rec_value[id[9:0]] = r.value;
          rec_prev[id[9:0]] = LINK_NONE;
          rec_next[id[9:0]] = r.head;
          if (r.head != LINK_NONE) rec_prev[r.head[9:0]] = id;
          o.new_index = id;
          o.head_out = id;
        end
      end
      OP_UNLINK: begin
        if (!is_live({1'b0, r.idx})) begin
          o.status = ST_NOUSE;
        end else begin
          p = rec_prev[r.idx];
          n = rec_next[r.idx];
          if (p < DEPTH) rec_next[p[9:0]] = n;
          else o.head_out = n;
          if (n < DEPTH) rec_prev[n[9:0]] = p;
          rec_used[r.idx] = 1'b0;
          free_push({1'b0, r.idx});
        end
      end
      OP_SETVAL: begin
        if (!is_live({1'b0, r.idx})) o.status = ST_NOUSE;
        else rec_value[r.idx] = r.value;
      end
      OP_READ: begin
        if (!is_live({1'b0, r.idx})) begin
          o.status = ST_NOUSE;
        end else begin
          o.rkey = rec_key[r.idx];
          o.rtype = rec_type[r.idx];
          o.rvalue = rec_value[r.idx];
          o.rnext = rec_next[r.idx];
          o.rused = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!head_ok) begin
          o.status = ST_NOUSE;
        end else begin
          cur = r.head;
          while (is_live(cur)) begin
            nxt = rec_next[cur[9:0]];
            rec_used[cur[9:0]] = 1'b0;
            free_push(cur);
            cur = nxt;
          end
          o.head_out = LINK_NONE;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [10:0] head,
                         input logic [9:0] idx, input logic [31:0] k,
                         input logic [31:0] t, input logic [31:0] v);
    op_req_t r;
    r = '{opcode: op, head: head, idx: idx, key: k, ptype: t, value: v};
    pending_results.insert(pending_results.size(), predict_store_op(r));
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.chain_head_in <= head;
    req.record_index <= idx;
    req.prop_key <= k;
    req.prop_type <= t;
    req.prop_value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = v;
  endtask

  always @(posedge clk) begin
    op_rsp_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, status %0d", rsp.status);
        end else begin
          e = pending_results.pop_front();
          if (rsp.status !== e.status || rsp.new_index !== e.new_index ||
              rsp.chain_head_out !== e.head_out || rsp.read_key !== e.rkey ||
              rsp.read_type !== e.rtype || rsp.read_value !== e.rvalue ||
              rsp.read_next !== e.rnext || rsp.read_in_use !== e.rused) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st=%0d new=%0d head=%0d k=%h t=%h v=%h nx=%0d u=%0b",
                       e.status, e.new_index, e.head_out, e.rkey, e.rtype, e.rvalue,
                       e.rnext, e.rused);
              $display("          got st=%0d new=%0d head=%0d k=%h t=%h v=%h nx=%0d u=%0b",
                       rsp.status, rsp.new_index, rsp.chain_head_out, rsp.read_key,
                       rsp.read_type, rsp.read_value, rsp.read_next, rsp.read_in_use);
            end
          end
        end
      end
    end
    rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic [9:0] pick_index();
    logic [9:0] i;
    int unsigned lim;
    if ($urandom_range(0, 99) < 75 && bump > 0) begin
      lim = (bump > DEPTH) ? DEPTH : bump;
      for (int n = 0; n < 16; n++) begin
        i = 10'($urandom_range(0, lim - 1));
        if (rec_used[i]) return i;
      end
    end
    return 10'($urandom_range(0, DEPTH - 1));
  endfunction

  task automatic random_request();
    int w;
    int c;
    logic [10:0] h;
    logic [9:0] i;
    op_rsp_t o;
    logic [OP_W-1:0] op;
    w = $urandom_range(0, 99);
    c = $urandom_range(0, NCHAIN - 1);
    if (w < 40) op = OP_ADD;
    else if (w < 52) op = OP_UNLINK;
    else if (w < 64) op = OP_SETVAL;
    else if (w < 84) op = OP_READ;
    else if (w < 94) op = OP_RELEASE;
    else op = 3'($urandom_range(5, 7));
    w = $urandom_range(0, 99);
    if (w < 65) h = chain_heads[c];
    else if (w < 80) h = LINK_NONE;
    else h = 11'($urandom_range(0, DEPTH));
    i = pick_index();
    send_op(op, h, i, $urandom, $urandom, $urandom);
    o = pending_results[$];
    if (h == chain_heads[c] && (op == OP_ADD || op == OP_RELEASE || op == OP_UNLINK))
      chain_heads[c] = o.head_out;
  endtask

  task automatic run_random(input int n, input int sidle, input int rstall,
                            input bit pause);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < n; k++) begin
      if (pause && k == n / 2) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      random_request();
    end
    drain();
  endtask

  task automatic test_directed();
    logic [10:0] a;
    logic [10:0] b;
    logic [10:0] c;
    write_capacity(11'd1024);
    send_op(OP_READ, LINK_NONE, 10'd0, '0, '0, '0);
    send_op(OP_ADD, LINK_NONE, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    a = pending_results[$].head_out;
    send_op(OP_ADD, a, 10'd1023, 32'h0, 32'h0, 32'h0);
    b = pending_results[$].head_out;
    send_op(OP_ADD, a, 10'd0, 32'h1234_5678, 32'hA5A5_5A5A, 32'h8000_0001);
    c = pending_results[$].head_out;
    send_op(OP_READ, b, a[9:0], '0, '0, '0);
    send_op(OP_SETVAL, b, b[9:0], '0, '0, 32'hDEAD_BEEF);
    send_op(OP_READ, b, b[9:0], '0, '0, '0);
    send_op(OP_ADD, 11'd700, 10'd0, 32'h1, 32'h2, 32'h3);
    send_op(OP_RELEASE, 11'd700, 10'd0, '0, '0, '0);
    send_op(OP_UNLINK, b, 10'd1023, '0, '0, '0);
    send_op(OP_SETVAL, b, 10'd900, '0, '0, 32'h5);
    send_op(OP_UNLINK, c, c[9:0], '0, '0, '0);
    send_op(OP_READ, b, a[9:0], '0, '0, '0);
    send_op(OP_UNLINK, b, a[9:0], '0, '0, '0);
    send_op(3'd5, b, 10'd3, 32'h5555_5555, '0, '0);
    send_op(3'd6, LINK_NONE, 10'd1023, '0, '0, '0);
    send_op(3'd7, 11'd1023, 10'd512, '0, '0, '0);
    send_op(OP_RELEASE, b, 10'd0, '0, '0, '0);
    send_op(OP_RELEASE, LINK_NONE, 10'd0, '0, '0, '0);
    send_op(OP_READ, LINK_NONE, b[9:0], '0, '0, '0);
    drain();
  endtask

  task automatic test_capacity_limits();
    write_capacity(11'd0);
    send_op(OP_ADD, LINK_NONE, 10'd0, 32'h11, 32'h22, 32'h33);
    write_capacity(11'd1);
    send_op(OP_ADD, LINK_NONE, 10'd0, 32'h44, 32'h55, 32'h66);
    send_op(OP_ADD, LINK_NONE, 10'd0, 32'h77, 32'h88, 32'h99);
    drain();
  endtask

  task automatic test_random_no_idle();
    write_capacity(11'd1024);
    run_random(130, 0, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    write_capacity(11'd2047);
    run_random(120, 47, 0, 1);
  endtask

  task automatic test_random_receiver_stall();
    write_capacity(11'd24);
    run_random(120, 0, 47, 0);
  endtask

  task automatic test_random_both_idle();
    write_capacity(11'd1);
    run_random(40, 13, 13, 0);
    write_capacity(11'd1024);
    run_random(100, 13, 13, 1);
  endtask

  initial begin
    req.valid <= 1'b0;
    req.opcode <= '0;
    req.chain_head_in <= '0;
    req.record_index <= '0;
    req.prop_key <= '0;
    req.prop_type <= '0;
    req.prop_value <= '0;
    for (int i = 0; i < DEPTH; i++) rec_used[i] = 1'b0;
    free_cnt = 0;
    bump = 0;
    capacity = 11'd1024;
    for (int i = 0; i < NCHAIN; i++) chain_heads[i] = LINK_NONE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity_limits();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
